### hw/rtl/cdo_pkg.sv
// Package for the calendar date day offset core: microcode types, control words,
// the microprogram table and month length helpers. No dependencies.
`timescale 1ns / 1ps

package cdo_pkg;

   localparam int unsigned YEAR_MAX      = 9999;
   localparam int unsigned YEAR_CYCLE    = 400;
   localparam int unsigned MONTHS        = 12;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   typedef logic [2:0] step_type;

   localparam step_type STEP_MOD   = 3'd0;
   localparam step_type STEP_CHECK = 3'd1;
   localparam step_type STEP_FWD   = 3'd2;
   localparam step_type STEP_BACK  = 3'd3;
   localparam step_type STEP_DONE  = 3'd4;

   typedef enum logic [4:0] {
      OP_MOD   = 5'b00001,
      OP_CHECK = 5'b00010,
      OP_FWD   = 5'b00100,
      OP_BACK  = 5'b01000,
      OP_DONE  = 5'b10000
   } op_type;

   typedef struct packed {
      op_type   op;
      step_type jmp_true;
      step_type jmp_false;
   } uword_type;

   typedef struct packed {
      logic   load;
      logic   exec;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic cond;
      logic fail;
   } flags_type;

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      unique case (step)
         STEP_MOD:   w = '{op: OP_MOD,   jmp_true: STEP_MOD,  jmp_false: STEP_CHECK};
         STEP_CHECK: w = '{op: OP_CHECK, jmp_true: STEP_FWD,  jmp_false: STEP_FWD};
         STEP_FWD:   w = '{op: OP_FWD,   jmp_true: STEP_FWD,  jmp_false: STEP_BACK};
         STEP_BACK:  w = '{op: OP_BACK,  jmp_true: STEP_BACK, jmp_false: STEP_DONE};
         default:    w = '{op: OP_DONE,  jmp_true: STEP_DONE, jmp_false: STEP_DONE};
      endcase
      return w;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### hw/rtl/cdo_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on cdo_pkg.
`timescale 1ns / 1ps

module cdo_seq
   import cdo_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output cmd_type   cmd,
   output logic      busy,
   output logic      rsp_valid
);

   step_type  step_ff, step_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;
   uword_type uword;

   always_comb begin
      uword    = ucode_rom(step_ff);
      step_in  = step_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = STEP_MOD;
         end
      end else if (uword.op == OP_DONE) begin
         busy_in  = 1'b0;
         valid_in = 1'b1;
      end else if (flags.fail) begin
         step_in = STEP_DONE;
      end else begin
         step_in = flags.cond ? uword.jmp_true : uword.jmp_false;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_MOD;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign cmd.load  = start && !busy_ff;
   assign cmd.exec  = busy_ff;
   assign cmd.op    = uword.op;
   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

### hw/rtl/cdo_datapath.sv
// Datapath: day, month, year and year-mod-400 registers with one month step per cycle.
// Depends on cdo_pkg; driven by cdo_seq.
`timescale 1ns / 1ps

module cdo_datapath
   import cdo_pkg::*;
(
   input  logic        clock,
   input  cmd_type     cmd,
   input  logic [4:0]  req_start_day,
   input  logic [3:0]  req_start_month,
   input  logic [13:0] req_start_year,
   input  logic [15:0] req_day_offset,
   output flags_type   flags,
   output logic [4:0]  rsp_result_day,
   output logic [3:0]  rsp_result_month,
   output logic [13:0] rsp_result_year,
   output logic [1:0]  rsp_status
);

   logic signed [16:0] d_ff, d_in;
   logic [3:0]  m_ff, m_in;
   logic [13:0] y_ff, y_in;
   logic [8:0]  r_ff, r_in;
   logic [4:0]  d0_ff, d0_in;
   logic [3:0]  m0_ff, m0_in;
   logic [13:0] y0_ff, y0_in;
   logic [1:0]  st_ff, st_in;
   logic [4:0]  od_ff, od_in;
   logic [3:0]  om_ff, om_in;
   logic [13:0] oy_ff, oy_in;
   logic [1:0]  os_ff, os_in;

   logic        leap;
   logic [4:0]  len_cur;
   logic [4:0]  len_prev;
   logic [3:0]  m_prev;
   logic [4:0]  len_start;

   always_comb begin
      leap = (r_ff[1:0] == 2'd0) && (r_ff != 9'd100) && (r_ff != 9'd200)
             && (r_ff != 9'd300);
      m_prev    = (m_ff == 4'd1) ? 4'(MONTHS) : m_ff - 4'd1;
      len_cur   = month_len(m_ff, leap);
      len_prev  = month_len(m_prev, leap);
      len_start = month_len(m0_ff, leap);
   end

   always_comb begin
      d_in  = d_ff;
      m_in  = m_ff;
      y_in  = y_ff;
      r_in  = r_ff;
      d0_in = d0_ff;
      m0_in = m0_ff;
      y0_in = y0_ff;
      st_in = st_ff;
      od_in = od_ff;
      om_in = om_ff;
      oy_in = oy_ff;
      os_in = os_ff;
      flags = '0;
      if (cmd.load) begin
         d_in  = $signed({12'd0, req_start_day}) + $signed({req_day_offset[15], req_day_offset});
         m_in  = req_start_month;
         y_in  = req_start_year;
         r_in  = 9'd0;
         d0_in = req_start_day;
         m0_in = req_start_month;
         y0_in = req_start_year;
         st_in = STATUS_OK;
      end else if (cmd.exec) begin
         unique case (cmd.op)
            OP_MOD: begin
               // reduce year mod 400 by repeated subtraction in y; the result goes to r and y is reloaded
               if (y_ff >= 14'(YEAR_CYCLE)) begin
                  flags.cond = 1'b1;
                  y_in = y_ff - 14'(YEAR_CYCLE);
               end else begin
                  r_in = y_ff[8:0];
                  y_in = y0_ff;
               end
            end
            OP_CHECK: begin
               if (m0_ff < 4'd1 || m0_ff > 4'(MONTHS) || y0_ff > 14'(YEAR_MAX)
                   || d0_ff < 5'd1 || d0_ff > len_start) begin
                  flags.fail = 1'b1;
                  st_in = STATUS_INVALID;
               end
            end
            OP_FWD: begin
               if (d_ff > $signed({12'd0, len_cur})) begin
                  flags.cond = 1'b1;
                  d_in = d_ff - $signed({12'd0, len_cur});
                  if (m_ff == 4'(MONTHS)) begin
                     if (y_ff == 14'(YEAR_MAX)) begin
                        flags.fail = 1'b1;
                        st_in = STATUS_RANGE;
                     end else begin
                        m_in = 4'd1;
                        y_in = y_ff + 14'd1;
                        r_in = (r_ff == 9'(YEAR_CYCLE - 1)) ? 9'd0 : r_ff + 9'd1;
                     end
                  end else begin
                     m_in = m_ff + 4'd1;
                  end
               end
            end
            OP_BACK: begin
               if (d_ff < 17'sd1) begin
                  flags.cond = 1'b1;
                  if (m_ff == 4'd1 && y_ff == 14'd0) begin
                     flags.fail = 1'b1;
                     st_in = STATUS_RANGE;
                  end else begin
                     // previous month is February only within the same year
                     d_in = d_ff + $signed({12'd0, len_prev});
                     m_in = m_prev;
                     if (m_ff == 4'd1) begin
                        y_in = y_ff - 14'd1;
                        r_in = (r_ff == 9'd0) ? 9'(YEAR_CYCLE - 1) : r_ff - 9'd1;
                     end
                  end
               end
            end
            OP_DONE: begin
               if (st_ff == STATUS_OK) begin
                  od_in = d_ff[4:0];
                  om_in = m_ff;
                  oy_in = y_ff;
               end else begin
                  od_in = d0_ff;
                  om_in = m0_ff;
                  oy_in = y0_ff;
               end
               os_in = st_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      m_ff  <= m_in;
      y_ff  <= y_in;
      r_ff  <= r_in;
      d0_ff <= d0_in;
      m0_ff <= m0_in;
      y0_ff <= y0_in;
      st_ff <= st_in;
      od_ff <= od_in;
      om_ff <= om_in;
      oy_ff <= oy_in;
      os_ff <= os_in;
   end

   assign rsp_result_day   = od_ff;
   assign rsp_result_month = om_ff;
   assign rsp_result_year  = oy_ff;
   assign rsp_status       = os_ff;

endmodule

### hw/rtl/calendar_date_day_offset_core.sv
// Top level of the calendar date day offset core: sequencer plus datapath.
// Depends on cdo_pkg, cdo_seq and cdo_datapath.
//
//   channel  | transfer when      | payload
//   ---------+--------------------+----------------------------------------------
//   request  | start && !busy     | req_start_day/month/year, req_day_offset
//   response | rsp_valid (1 cyc)  | rsp_result_day/month/year, rsp_status
//
// One item at a time: the sequencer reduces the year mod 400, checks the start date,
// steps forward then back one month per cycle and ends in DONE, raising the strobe; an
// invalid date or a range error skips to DONE. busy is set by the transfer and holds
// until the strobe; a new start is taken in the strobe cycle. Synchronous reset clears
// the sequencer and the strobe. The receiver cannot stall: each result is shown once.
`timescale 1ns / 1ps

module calendar_date_day_offset_core
   import cdo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_start_day,
   input  logic [3:0]  req_start_month,
   input  logic [13:0] req_start_year,
   input  logic [15:0] req_day_offset,
   output logic        rsp_valid,
   output logic [4:0]  rsp_result_day,
   output logic [3:0]  rsp_result_month,
   output logic [13:0] rsp_result_year,
   output logic [1:0]  rsp_status
);

   cmd_type   cmd;
   flags_type flags;

   cdo_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .flags     (flags),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   cdo_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .req_day_offset   (req_day_offset),
      .flags            (flags),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_status       (rsp_status)
   );

endmodule

### dv/calendar_date_day_offset_core_tb.sv
// Testbench for calendar_date_day_offset_core: directed and random date shifts with
// random start gaps, checked field by field against a behavioral date walker.
// Depends on cdo_pkg and the core RTL.
`timescale 1ns / 1ps

module calendar_date_day_offset_core_tb
   import cdo_pkg::*;
;

   localparam int  RANDOM_ITEMS = 520;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [15:0] offset;
      int          gap;
      bit          drain;
   } date_req_type;

   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [1:0]  status;
   } shifted_date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [4:0]  req_start_day = '0;
   logic [3:0]  req_start_month = '0;
   logic [13:0] req_start_year = '0;
   logic [15:0] req_day_offset = '0;
   logic        busy;
   logic        rsp_valid;
   logic [4:0]  rsp_result_day;
   logic [3:0]  rsp_result_month;
   logic [13:0] rsp_result_year;
   logic [1:0]  rsp_status;

   date_req_type     pending_q[$];
   shifted_date_type shifted_q[$];
   logic             took = 1'b0;
   int               wait_cnt = 0;
   int               errors = 0;
   int               transfers = 0;
   int               n_ok = 0;
   int               n_invalid = 0;
   int               n_range = 0;
   longint           cycle_cnt = 0;

   calendar_date_day_offset_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .req_day_offset   (req_day_offset),
      .rsp_valid        (rsp_valid),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input int y);
      if (m == 2) return is_leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   function automatic shifted_date_type shift_date(input logic [4:0] sd,
                                                   input logic [3:0] sm,
                                                   input logic [13:0] sy,
                                                   input logic [15:0] off);
      shifted_date_type res;
      int d;
      int m;
      int y;
      bit out_of_range;
      res.day    = sd;
      res.month  = sm;
      res.year   = sy;
      res.status = STATUS_OK;
      if (int'(sm) < 1 || int'(sm) > int'(MONTHS) || int'(sy) > int'(YEAR_MAX) ||
          int'(sd) < 1 || int'(sd) > days_in_month(int'(sm), int'(sy))) begin
         res.status = STATUS_INVALID;
         return res;
      end
      d = int'(sd) + int'($signed(off));
      m = int'(sm);
      y = int'(sy);
      out_of_range = 1'b0;
      while (!out_of_range && d > days_in_month(m, y)) begin
         d -= days_in_month(m, y);
         m++;
         if (m > int'(MONTHS)) begin
            m = 1;
            y++;
            if (y > int'(YEAR_MAX)) out_of_range = 1'b1;
         end
      end
      while (!out_of_range && d < 1) begin
         m--;
         if (m < 1) begin
            m = int'(MONTHS);
            y--;
            if (y < 0) out_of_range = 1'b1;
         end
         if (!out_of_range) d += days_in_month(m, y);
      end
      if (out_of_range) begin
         res.status = STATUS_RANGE;
         return res;
      end
      res.day   = 5'(d);
      res.month = 4'(m);
      res.year  = 14'(y);
      return res;
   endfunction

   task automatic add_date(input int day, input int month, input int year, input int offset,
                           input bit drain);
      date_req_type r;
      r.day    = 5'(day);
      r.month  = 4'(month);
      r.year   = 14'(year);
      r.offset = 16'(offset);
      // bursts of back-to-back starts every third block of 40 items
      r.gap    = ((pending_q.size() / 40) % 3 == 1) ? 0 : int'($urandom_range(0, 7));
      r.drain  = drain;
      pending_q.push_back(r);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // drive at the falling edge; advance only after a transfer or while idle
   always @(negedge clock) begin : driver
      date_req_type nxt;
      if (reset) begin
         start    <= 1'b0;
         wait_cnt <= 0;
      end else if (!start || took) begin
         if (pending_q.size() == 0) begin
            start <= 1'b0;
         end else begin
            nxt = pending_q[0];
            if (wait_cnt < nxt.gap || (nxt.drain && (shifted_q.size() != 0 || busy))) begin
               start <= 1'b0;
               if (wait_cnt < nxt.gap) wait_cnt <= wait_cnt + 1;
            end else begin
               void'(pending_q.pop_front());
               req_start_day   <= nxt.day;
               req_start_month <= nxt.month;
               req_start_year  <= nxt.year;
               req_day_offset  <= nxt.offset;
               start           <= 1'b1;
               wait_cnt        <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      shifted_date_type want;
      took <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (shifted_q.size() == 0) begin
               errors++;
               $display("%0t: result with no transfer pending: expected none %s",
                        $time, "actual");
               $display("   %0d/%0d/%0d status %0d", rsp_result_day, rsp_result_month,
                        rsp_result_year, rsp_status);
            end else begin
               want = shifted_q.pop_front();
               check_field("day", want.day, rsp_result_day);
               check_field("month", want.month, rsp_result_month);
               check_field("year", want.year, rsp_result_year);
               check_field("status", want.status, rsp_status);
               case (want.status)
                  STATUS_OK:      n_ok++;
                  STATUS_INVALID: n_invalid++;
                  default:        n_range++;
               endcase
            end
         end
         if (start && !busy) begin
            shifted_q.push_back(shift_date(req_start_day, req_start_month, req_start_year,
                                           req_day_offset));
            transfers++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                  shifted_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int kind;
      int y;
      int m;
      int len;
      int off;
      add_date(1, 1, 2000, 0, 0);
      add_date(31, 12, 9999, 1, 0);
      add_date(1, 1, 0, -1, 0);
      add_date(29, 2, 2000, 0, 0);
      add_date(29, 2, 1900, 5, 0);
      add_date(29, 2, 0, 366, 0);
      add_date(0, 5, 2020, 3, 0);
      add_date(31, 4, 2021, 1, 0);
      add_date(31, 15, 2021, 1, 0);
      add_date(10, 0, 2021, 1, 0);
      add_date(10, 13, 2021, 1, 0);
      add_date(1, 1, 10000, 0, 0);
      add_date(31, 15, 16383, -1, 1);
      add_date(15, 6, 5000, 32767, 0);
      add_date(15, 6, 5000, -32768, 0);
      add_date(28, 2, 2023, 1, 0);
      add_date(28, 2, 2024, 1, 0);
      add_date(1, 3, 2100, -1, 0);
      add_date(31, 12, 1999, 1, 0);
      add_date(1, 1, 2000, -1, 0);
      add_date(1, 1, 9999, 32767, 0);
      add_date(1, 1, 0, 32767, 0);
      add_date(31, 12, 9910, 32767, 0);
      add_date(0, 0, 0, 0, 0);
      add_date(30, 2, 2024, -1, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            add_date($urandom, $urandom, $urandom, $urandom, i == 270);
         end else begin
            if (kind < 30)
               y = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(9960, 9999);
            else
               y = $urandom_range(0, 9999);
            m   = $urandom_range(1, 12);
            len = days_in_month(m, y);
            case ($urandom_range(0, 2))
               0:       off = int'($signed(16'($urandom)));
               1:       off = int'($urandom_range(0, 800)) - 400;
               default: off = int'($urandom_range(0, 6000)) - 3000;
            endcase
            if (kind < 15)
               add_date((len == 31) ? 0 : $urandom_range(len + 1, 31), m, y, off, i == 270);
            else
               add_date($urandom_range(1, len), m, y, off, i == 270);
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_q.size() != 0 || start || shifted_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d date shifts: %0d in range, %0d invalid dates, %0d out of range.",
               transfers, n_ok, n_invalid, n_range);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/cdo_pkg.sv
hw/rtl/cdo_seq.sv
hw/rtl/cdo_datapath.sv
hw/rtl/calendar_date_day_offset_core.sv
dv/calendar_date_day_offset_core_tb.sv
